/* rtl/lcd_mode_sequencer_top_assert.svh */
// Assertion macros for the LCD mode sequencer.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef LCD_MODE_SEQUENCER_TOP_ASSERT_SVH
`define LCD_MODE_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lms_pkg.sv */
// Constants for the LCD mode timing sequencer: field widths, tick counts and mode codes.
// No dependencies.
package lms_pkg;

  localparam int unsigned StampW = 32;
  localparam int unsigned CountW = 9;
  localparam int unsigned LineW  = 8;
  localparam int unsigned ModeW  = 2;

  // Timing in CPU ticks
  localparam int unsigned LineTicks   = 456;
  localparam int unsigned VblankTicks = 4560;
  localparam int unsigned VblankLines = 10;
  localparam int unsigned OamTicks    = 80;
  localparam int unsigned XferTicks   = 172;

  localparam logic [CountW-1:0] CountLine   = CountW'(LineTicks);
  localparam logic [CountW-1:0] CountVbLine = CountW'(VblankTicks / VblankLines);
  localparam logic [CountW-1:0] CountOamEnd = CountW'(LineTicks - OamTicks);
  localparam logic [CountW-1:0] CountXfrEnd = CountW'(LineTicks - OamTicks - XferTicks);

  // Line numbers
  localparam logic [LineW-1:0] LastVisible   = LineW'(143);
  localparam logic [LineW-1:0] LastLine      = LineW'(153);
  localparam logic [LineW-1:0] VblankIrqLine = LineW'(144);

  // Mode codes
  localparam logic [ModeW-1:0] ModeHblank = 2'd0;
  localparam logic [ModeW-1:0] ModeVblank = 2'd1;
  localparam logic [ModeW-1:0] ModeOam    = 2'd2;
  localparam logic [ModeW-1:0] ModeXfer   = 2'd3;

endpackage

/* rtl/lcd_mode_sequencer_top.sv */
// LCD mode sequencer, top level: elapsed-tick countdown, mode state and output register.
// Depends on lms_pkg and lcd_mode_sequencer_top_assert.svh.

// Each accepted tick stamp request advances the display timing by the ticks
// elapsed since the previous stamp (a stamp lower than the previous one counts
// from zero) and yields one result: mode, line number, STAT and vblank
// interrupt requests, and a render strobe with the row to draw. One request is
// taken per clock; its result appears in the output register on the next cycle.
// The only limit on throughput is the output side: while a result waits under
// out_stall_i, in_stall_o is raised. At most one mode change happens per request.
module lcd_mode_sequencer_top
  import lms_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [StampW-1:0] tick_stamp_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ModeW-1:0]  mode_o,
  output logic [LineW-1:0]  line_number_o,
  output logic              stat_irq_o,
  output logic              vblank_irq_o,
  output logic              render_strobe_o,
  output logic [LineW-1:0]  render_row_o
);

`include "lcd_mode_sequencer_top_assert.svh"

  // Sequencer state
  logic [StampW-1:0] prev_q;
  logic [CountW-1:0] count_q, count_d;
  logic [ModeW-1:0]  mode_q, mode_d;
  logic [LineW-1:0]  line_q, line_d;
  logic              sent_q, sent_d;

  // Output register
  logic              out_valid_q;
  logic [ModeW-1:0]  res_mode_q;
  logic [LineW-1:0]  res_line_q;
  logic              res_stat_q, res_stat_d;
  logic              res_vbl_q, res_vbl_d;
  logic              res_strobe_q, res_strobe_d;
  logic [LineW-1:0]  res_row_q, res_row_d;

  logic              in_accept;
  logic [StampW-1:0] prev_eff;
  logic [StampW-1:0] elapsed;
  logic [CountW-1:0] count_sub;
  logic [LineW-1:0]  line_inc;

  // Handshake: stall only while a result is held back
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // Elapsed ticks and saturating countdown
  assign prev_eff  = (prev_q > tick_stamp_i) ? '0 : prev_q;
  assign elapsed   = tick_stamp_i - prev_eff;
  assign count_sub = (elapsed > StampW'(count_q)) ? '0 : (count_q - elapsed[CountW-1:0]);
  assign line_inc  = line_q + LineW'(1);

  // Mode stepping
  always_comb begin
    count_d      = count_sub;
    mode_d       = mode_q;
    line_d       = line_q;
    sent_d       = sent_q;
    res_stat_d   = 1'b0;
    res_vbl_d    = 1'b0;
    res_strobe_d = 1'b0;
    res_row_d    = '0;
    unique case (mode_q)
      ModeHblank: begin
        if (!sent_q) begin
          sent_d     = 1'b1;
          res_stat_d = 1'b1;
        end
        if (count_sub == '0) begin
          line_d = line_inc;
          sent_d = 1'b0;
          if (line_inc > LastVisible) begin
            mode_d  = ModeVblank;
            count_d = CountVbLine;
          end else begin
            mode_d  = ModeOam;
            count_d = CountLine;
          end
        end
      end
      ModeVblank: begin
        res_vbl_d = (line_q == VblankIrqLine);
        if (count_sub == '0) begin
          if (line_inc > LastLine) begin
            mode_d  = ModeOam;
            count_d = CountLine;
            line_d  = '0;
          end else begin
            line_d  = line_inc;
            count_d = CountVbLine;
          end
        end
      end
      ModeOam: begin
        if (count_sub <= CountOamEnd) mode_d = ModeXfer;
      end
      default: begin
        if (count_sub <= CountXfrEnd) begin
          res_strobe_d = 1'b1;
          res_row_d    = line_q;
          mode_d       = ModeHblank;
        end
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      count_q <= CountLine;
      mode_q  <= ModeOam;
      line_q  <= '0;
      sent_q  <= 1'b0;
    end else if (in_accept) begin
      prev_q  <= tick_stamp_i;
      count_q <= count_d;
      mode_q  <= mode_d;
      line_q  <= line_d;
      sent_q  <= sent_d;
    end
  end

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, loaded only with a new request
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_mode_q   <= mode_d;
      res_line_q   <= line_d;
      res_stat_q   <= res_stat_d;
      res_vbl_q    <= res_vbl_d;
      res_strobe_q <= res_strobe_d;
      res_row_q    <= res_row_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mode_o          = res_mode_q;
  assign line_number_o   = res_line_q;
  assign stat_irq_o      = res_stat_q;
  assign vblank_irq_o    = res_vbl_q;
  assign render_strobe_o = res_strobe_q;
  assign render_row_o    = res_row_q;

  // Checks
  `LMS_ASSERT_NXT(a_accept_gives_result, in_accept, out_valid_o, "accepted request lost")
  `LMS_ASSERT_IMP(a_line_in_range, 1'b1, line_q <= LastLine, "line counter past last line")
  `LMS_ASSERT_IMP(a_strobe_enters_hblank, out_valid_o && render_strobe_o,
                  mode_o == ModeHblank, "render strobe without hblank entry")
  `LMS_ASSERT_IMP(a_vblank_irq_line, out_valid_o && vblank_irq_o,
                  (line_number_o == VblankIrqLine) || (line_number_o == VblankIrqLine + 8'd1),
                  "vblank interrupt off its line")

endmodule
